FILE: design/rbsi_pkg.sv
// ============================================================================
// Ray box slab intersect package
// Shared defaults and register indexes for the ray versus box tester.
// ============================================================================
package rbsi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int AXES            = 3;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BOX_MAX_Z = 3'd5;

endpackage

FILE: design/rbsi_if.sv
// ============================================================================
// Ray box slab intersect channels
// Valid/ready channels for ray words and result words.
// ============================================================================
interface rbsi_ray_if #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;
    logic signed [COORD_WIDTH-1:0] param_lo;
    logic signed [COORD_WIDTH-1:0] param_hi;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               param_lo, param_hi,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               param_lo, param_hi,
        output ready
    );
endinterface

interface rbsi_hit_if #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (
        output valid, hit, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, hit, point_x, point_y, point_z,
        output ready
    );
endinterface

FILE: design/rbsi_div_pipe.sv
// ============================================================================
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage.
// ============================================================================
module rbsi_div_pipe #(
    parameter int DEN_WIDTH = 32,
    parameter int NUM_WIDTH = 49
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [NUM_WIDTH-1:0] num,
    input  logic [DEN_WIDTH-1:0] den,
    output logic [NUM_WIDTH-1:0] quo
);
    logic [NUM_WIDTH-1:0] num_reg [1:NUM_WIDTH];
    logic [DEN_WIDTH-1:0] den_reg [1:NUM_WIDTH];
    logic [DEN_WIDTH-1:0] rem_reg [1:NUM_WIDTH];
    logic [NUM_WIDTH-1:0] quo_reg [1:NUM_WIDTH];

    for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_stage
        logic [NUM_WIDTH-1:0] cur_num;
        logic [DEN_WIDTH-1:0] cur_den;
        logic [DEN_WIDTH-1:0] cur_rem;
        logic [NUM_WIDTH-1:0] cur_quo;
        logic [DEN_WIDTH:0]   trial;
        logic [DEN_WIDTH:0]   diff;
        logic [DEN_WIDTH-1:0] rem_next;
        logic                 bit_next;

        if (i == 0) begin : g_first
            assign cur_num = num;
            assign cur_den = den;
            assign cur_rem = '0;
            assign cur_quo = '0;
        end else begin : g_rest
            assign cur_num = num_reg[i];
            assign cur_den = den_reg[i];
            assign cur_rem = rem_reg[i];
            assign cur_quo = quo_reg[i];
        end

        always_comb
        begin
            trial = {cur_rem, cur_num[NUM_WIDTH-1]};
            diff  = trial - {1'b0, cur_den};
            if (!diff[DEN_WIDTH])
            begin
                rem_next = diff[DEN_WIDTH-1:0];
                bit_next = 1'b1;
            end
            else
            begin
                rem_next = trial[DEN_WIDTH-1:0];
                bit_next = 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i+1] <= {cur_num[NUM_WIDTH-2:0], 1'b0};
                den_reg[i+1] <= cur_den;
                rem_reg[i+1] <= rem_next;
                quo_reg[i+1] <= {cur_quo[NUM_WIDTH-2:0], bit_next};
            end
        end
    end

    assign quo = quo_reg[NUM_WIDTH];
endmodule

FILE: design/ray_box_slab_intersect.sv
// ============================================================================
// Ray versus axis-aligned box intersection
// Slab test in signed fixed point with exact division and a saturated point.
// ============================================================================
// The box bounds are six registers written through cfg_we, cfg_index and
// cfg_data; the user must write them only while no ray is in flight, which
// the block itself does not enforce. Rays arrive as words on the ray channel
// and one result word per ray leaves on the result channel, in order.
// The pipeline takes one ray per cycle while the result channel is not
// stalled. The six slab divisions run in pipelined restoring dividers, one
// quotient bit per stage, and those set the depth.
// The whole pipeline advances together. When the result word is valid and
// the receiver holds ready low, every stage holds and ray.ready is low, so no
// word is lost or repeated.
// Reset clears all valid bits and the box registers to zero. A miss returns
// hit low with a zero point.
module ray_box_slab_intersect #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rbsi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]               cfg_data,
    rbsi_ray_if.sink                             ray,
    rbsi_hit_if.source                           result
);
    import rbsi_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int NW    = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int QW    = NW + 1;
    localparam int SW    = 2 * COORD_WIDTH - FRAC_BITS + 2;
    localparam int PW    = 2 * COORD_WIDTH - FRAC_BITS;
    localparam int ST_A  = NW + 1;
    localparam int ST_B  = NW + 2;
    localparam int ST_C  = NW + 3;
    localparam int ST_D  = NW + 4;
    localparam int ST_E  = NW + 5;
    localparam int ST_F  = NW + 6;
    localparam int LAST  = NW + 7;

    logic signed [W-1:0] box_min_reg [AXES];
    logic signed [W-1:0] box_max_reg [AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BOX_MIN_X: box_min_reg[0] <= cfg_data;
                CFG_BOX_MIN_Y: box_min_reg[1] <= cfg_data;
                CFG_BOX_MIN_Z: box_min_reg[2] <= cfg_data;
                CFG_BOX_MAX_X: box_max_reg[0] <= cfg_data;
                CFG_BOX_MAX_Y: box_max_reg[1] <= cfg_data;
                CFG_BOX_MAX_Z: box_max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic valid_reg [0:LAST];

    assign en        = !valid_reg[LAST] || result.ready;
    assign ray.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= ray.valid;
            for (int i = 1; i <= LAST; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // Input stage: slab numerators, denominators and slab membership.
    logic signed [W-1:0] o_in [AXES];
    logic signed [W-1:0] d_in [AXES];
    logic [W:0]          dlo_in [AXES];
    logic [W:0]          dhi_in [AXES];
    logic [W:0]          mlo_in [AXES];
    logic [W:0]          mhi_in [AXES];
    logic [W-1:0]        dmag_in [AXES];
    logic                in_slab_in [AXES];

    assign o_in[0] = ray.origin_x;
    assign o_in[1] = ray.origin_y;
    assign o_in[2] = ray.origin_z;
    assign d_in[0] = ray.dir_x;
    assign d_in[1] = ray.dir_y;
    assign d_in[2] = ray.dir_z;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            dlo_in[a] = {box_min_reg[a][W-1], box_min_reg[a]} - {o_in[a][W-1], o_in[a]};
            dhi_in[a] = {box_max_reg[a][W-1], box_max_reg[a]} - {o_in[a][W-1], o_in[a]};
            mlo_in[a] = dlo_in[a][W] ? (~dlo_in[a]) + {{W{1'b0}}, 1'b1} : dlo_in[a];
            mhi_in[a] = dhi_in[a][W] ? (~dhi_in[a]) + {{W{1'b0}}, 1'b1} : dhi_in[a];
            dmag_in[a] = d_in[a][W-1] ? (~d_in[a]) + {{(W-1){1'b0}}, 1'b1} : d_in[a];
            in_slab_in[a] = (o_in[a] >= box_min_reg[a]) && (o_in[a] <= box_max_reg[a]);
        end
    end

    logic [NW-1:0]       num_lo_reg [AXES];
    logic [NW-1:0]       num_hi_reg [AXES];
    logic signed [W-1:0] o_line     [0:ST_F][AXES];
    logic [W-1:0]        dmag_line  [0:ST_F][AXES];
    logic                dneg_line  [0:ST_F][AXES];
    logic                dzero_line [0:ST_F][AXES];
    logic                ins_line   [0:ST_F][AXES];
    logic                nlo_line   [0:ST_F][AXES];
    logic                nhi_line   [0:ST_F][AXES];
    logic signed [W-1:0] tlo_line   [0:ST_F];
    logic signed [W-1:0] thi_line   [0:ST_F];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                num_lo_reg[a]       <= {mlo_in[a], {FRAC_BITS{1'b0}}};
                num_hi_reg[a]       <= {mhi_in[a], {FRAC_BITS{1'b0}}};
                o_line[0][a]        <= o_in[a];
                dmag_line[0][a]     <= dmag_in[a];
                dneg_line[0][a]     <= d_in[a][W-1];
                dzero_line[0][a]    <= (d_in[a] == '0);
                ins_line[0][a]      <= in_slab_in[a];
                nlo_line[0][a]      <= dlo_in[a][W] ^ d_in[a][W-1];
                nhi_line[0][a]      <= dhi_in[a][W] ^ d_in[a][W-1];
            end
            tlo_line[0] <= ray.param_lo;
            thi_line[0] <= ray.param_hi;
            for (int i = 1; i <= ST_F; i++)
            begin
                o_line[i]     <= o_line[i-1];
                dmag_line[i]  <= dmag_line[i-1];
                dneg_line[i]  <= dneg_line[i-1];
                dzero_line[i] <= dzero_line[i-1];
                ins_line[i]   <= ins_line[i-1];
                nlo_line[i]   <= nlo_line[i-1];
                nhi_line[i]   <= nhi_line[i-1];
                tlo_line[i]   <= tlo_line[i-1];
                thi_line[i]   <= thi_line[i-1];
            end
        end
    end

    logic [NW-1:0] quo_lo [AXES];
    logic [NW-1:0] quo_hi [AXES];

    for (genvar a = 0; a < AXES; a++) begin : g_div
        rbsi_div_pipe #(
            .DEN_WIDTH (W),
            .NUM_WIDTH (NW)
        ) u_div_lo (
            .clk (clk),
            .en  (en),
            .num (num_lo_reg[a]),
            .den (dmag_line[0][a]),
            .quo (quo_lo[a])
        );
        rbsi_div_pipe #(
            .DEN_WIDTH (W),
            .NUM_WIDTH (NW)
        ) u_div_hi (
            .clk (clk),
            .en  (en),
            .num (num_hi_reg[a]),
            .den (dmag_line[0][a]),
            .quo (quo_hi[a])
        );
    end

    // Signed slab entry and exit, ordered by direction sign.
    logic signed [QW-1:0] sl_a [AXES];
    logic signed [QW-1:0] sh_a [AXES];
    logic signed [QW-1:0] t0_reg [0:2][AXES];
    logic signed [QW-1:0] t1_reg [0:2][AXES];

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            sl_a[a] = nlo_line[NW][a] ? -$signed({1'b0, quo_lo[a]}) : $signed({1'b0, quo_lo[a]});
            sh_a[a] = nhi_line[NW][a] ? -$signed({1'b0, quo_hi[a]}) : $signed({1'b0, quo_hi[a]});
        end
    end

    function automatic logic [2*QW:0] axis_step(
        input logic signed [QW-1:0] te,
        input logic signed [QW-1:0] tx,
        input logic                 miss,
        input logic signed [QW-1:0] t0,
        input logic signed [QW-1:0] t1,
        input logic                 dzero,
        input logic                 in_slab
    );
        logic signed [QW-1:0] te_n;
        logic signed [QW-1:0] tx_n;
        logic                 miss_n;
        te_n   = te;
        tx_n   = tx;
        miss_n = miss;
        if (dzero)
        begin
            miss_n = miss_n || !in_slab;
        end
        else
        begin
            if (t0 > te_n)
            begin
                te_n = t0;
            end
            if (t1 < tx_n)
            begin
                tx_n = t1;
            end
        end
        miss_n = miss_n || (tx_n <= te_n);
        return {miss_n, te_n, tx_n};
    endfunction

    logic signed [QW-1:0] te_reg   [0:2];
    logic signed [QW-1:0] tx_reg   [0:2];
    logic                 miss_reg [0:2];
    logic [2*QW:0]        step_b;
    logic [2*QW:0]        step_c;
    logic [2*QW:0]        step_d;

    always_comb
    begin
        step_b = axis_step(QW'(tlo_line[ST_A]), QW'(thi_line[ST_A]), 1'b0,
                           t0_reg[0][0], t1_reg[0][0],
                           dzero_line[ST_A][0], ins_line[ST_A][0]);
        step_c = axis_step(te_reg[0], tx_reg[0], miss_reg[0],
                           t0_reg[1][1], t1_reg[1][1],
                           dzero_line[ST_B][1], ins_line[ST_B][1]);
        step_d = axis_step(te_reg[1], tx_reg[1], miss_reg[1],
                           t0_reg[2][2], t1_reg[2][2],
                           dzero_line[ST_C][2], ins_line[ST_C][2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                t0_reg[0][a] <= dneg_line[NW][a] ? sh_a[a] : sl_a[a];
                t1_reg[0][a] <= dneg_line[NW][a] ? sl_a[a] : sh_a[a];
                t0_reg[1][a] <= t0_reg[0][a];
                t1_reg[1][a] <= t1_reg[0][a];
                t0_reg[2][a] <= t0_reg[1][a];
                t1_reg[2][a] <= t1_reg[1][a];
            end
            {miss_reg[0], te_reg[0], tx_reg[0]} <= step_b;
            {miss_reg[1], te_reg[1], tx_reg[1]} <= step_c;
            {miss_reg[2], te_reg[2], tx_reg[2]} <= step_d;
        end
    end

    // Final decision and parameter magnitude.
    logic                 inside_e;
    logic                 hit_e;
    logic signed [QW-1:0] t_e;
    logic [W-1:0]         tw_e;
    logic                 hit_e_reg;
    logic [W-1:0]         tmag_e_reg;
    logic                 tneg_e_reg;

    always_comb
    begin
        inside_e = ins_line[ST_D][0] && ins_line[ST_D][1] && ins_line[ST_D][2];
        hit_e    = !miss_reg[2] && (inside_e ||
                   ((QW'(tlo_line[ST_D]) < te_reg[2]) && (te_reg[2] < QW'(thi_line[ST_D]))));
        t_e      = inside_e ? tx_reg[2] : te_reg[2];
        tw_e     = t_e[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_e_reg  <= hit_e;
            tneg_e_reg <= t_e[QW-1];
            tmag_e_reg <= t_e[QW-1] ? (~tw_e) + {{(W-1){1'b0}}, 1'b1} : tw_e;
        end
    end

    // Products of parameter and direction magnitudes.
    logic [2*W-1:0] prod_f_reg [AXES];
    logic           pneg_f_reg [AXES];
    logic           hit_f_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                prod_f_reg[a] <= {{W{1'b0}}, tmag_e_reg} * {{W{1'b0}}, dmag_line[ST_E][a]};
                pneg_f_reg[a] <= tneg_e_reg ^ dneg_line[ST_E][a];
            end
            hit_f_reg <= hit_e_reg;
        end
    end

    // Point sum and saturation into the output register.
    logic signed [SW-1:0] sum_g [AXES];
    logic signed [SW-1:0] pm_g  [AXES];
    logic signed [W-1:0]  sat_g [AXES];
    logic signed [SW-1:0] max_g;
    logic signed [SW-1:0] min_g;
    logic                 hit_reg;
    logic signed [W-1:0]  point_reg [AXES];

    always_comb
    begin
        max_g = SW'({1'b0, {(W-1){1'b1}}});
        min_g = -max_g - SW'(1);
        for (int a = 0; a < AXES; a++)
        begin
            pm_g[a]  = $signed({2'b00, prod_f_reg[a][2*W-1:FRAC_BITS]});
            if (pneg_f_reg[a])
            begin
                pm_g[a] = -pm_g[a];
            end
            sum_g[a] = SW'(o_line[ST_F][a]) + pm_g[a];
            if (sum_g[a] > max_g)
            begin
                sat_g[a] = max_g[W-1:0];
            end
            else if (sum_g[a] < min_g)
            begin
                sat_g[a] = min_g[W-1:0];
            end
            else
            begin
                sat_g[a] = sum_g[a][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_f_reg;
            for (int a = 0; a < AXES; a++)
            begin
                point_reg[a] <= hit_f_reg ? sat_g[a] : '0;
            end
        end
    end

    assign result.valid   = valid_reg[LAST];
    assign result.hit     = hit_reg;
    assign result.point_x = point_reg[0];
    assign result.point_y = point_reg[1];
    assign result.point_z = point_reg[2];

    // A miss always carries a zero point.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.hit |->
            result.point_x == '0 && result.point_y == '0 && result.point_z == '0)
        else $error("miss result with nonzero point");

    // The pipeline holds as a whole while the output word waits.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !ray.ready)
        else $error("input accepted during output stall");

    // An accepted ray enters the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        ray.valid && ray.ready |=> valid_reg[0])
        else $error("accepted ray did not enter the pipeline");

    // The word in the stage before the output stays valid across a stall.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST - 1] && !en |=> valid_reg[LAST - 1])
        else $error("stage lost its word during stall");
endmodule

FILE: bench/tb_ray_box_slab_intersect.sv
// ============================================================================
// Ray box slab intersect testbench
// Drives rays through the slab tester under several box settings, predicts
// each result word in fixed point and compares it field by field, in order.
// ============================================================================
`timescale 1ns / 100ps

module tb_ray_box_slab_intersect;

    import rbsi_pkg::*;

    localparam int CW          = 32;
    localparam int FB          = 16;
    localparam int LATENCY     = CW + FB + 9;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_RAYS = 400;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t ox, oy, oz, dx, dy, dz, lo, hi;
    } ray_t;

    typedef struct {
        logic   hit;
        coord_t px, py, pz;
    } hit_word_t;

    typedef struct {
        ray_t      r;
        logic      has_exp;
        hit_word_t exp;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CW-1:0] cfg_data;

    rbsi_ray_if #(.COORD_WIDTH(CW)) ray_ch ();
    rbsi_hit_if #(.COORD_WIDTH(CW)) hit_ch ();

    ray_box_slab_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .ray      (ray_ch.sink),
        .result   (hit_ch.source)
    );

    longint    box_lo[3];
    longint    box_hi[3];
    hit_word_t pending_hits[$];
    int        errors;
    int        cycles;
    int        rays_sent;
    int        words_seen;
    int        hits_seen;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint quot_q16(longint num, longint den);
        longint unsigned q;
        longint unsigned mn;
        longint unsigned md;
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        q  = (mn << FB) / md;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic coord_t walk_coord(longint o, longint t, longint d);
        longint unsigned pm;
        longint p;
        longint r;
        pm = (((t < 0) ? -t : t) * ((d < 0) ? -d : d)) >> FB;
        p  = longint'(pm);
        if ((t < 0) != (d < 0))
            p = -p;
        r = o + p;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return coord_t'(r);
    endfunction

    function automatic hit_word_t slab_predict(ray_t r);
        hit_word_t w;
        longint o[3];
        longint d[3];
        longint te;
        longint tx;
        longint t0;
        longint t1;
        longint s;
        longint t;
        int     in_count;
        logic   hit;
        logic   in_slab;
        o = '{longint'(r.ox), longint'(r.oy), longint'(r.oz)};
        d = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
        te = r.lo;
        tx = r.hi;
        in_count = 0;
        hit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            in_slab = o[i] >= box_lo[i] && o[i] <= box_hi[i];
            if (in_slab)
                in_count++;
            if (d[i] == 0)
            begin
                if (!in_slab)
                begin
                    hit = 1'b0;
                    break;
                end
            end
            else
            begin
                t0 = quot_q16(box_lo[i] - o[i], d[i]);
                t1 = quot_q16(box_hi[i] - o[i], d[i]);
                if (d[i] < 0)
                begin
                    s  = t0;
                    t0 = t1;
                    t1 = s;
                end
                if (t0 > te)
                    te = t0;
                if (t1 < tx)
                    tx = t1;
            end
            if (tx <= te)
            begin
                hit = 1'b0;
                break;
            end
        end
        if (hit && in_count != 3 && !(r.lo < te && te < r.hi))
            hit = 1'b0;
        w = '{1'b0, '0, '0, '0};
        if (hit)
        begin
            t = (in_count == 3) ? tx : te;
            w.hit = 1'b1;
            w.px = walk_coord(o[0], t, d[0]);
            w.py = walk_coord(o[1], t, d[1]);
            w.pz = walk_coord(o[2], t, d[2]);
        end
        return w;
    endfunction

    task automatic write_box(logic [CFG_INDEX_WIDTH-1:0] idx, coord_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx < 3)
            box_lo[idx] = value;
        else
            box_hi[idx-3] = value;
    endtask

    task automatic set_box(coord_t x0, coord_t y0, coord_t z0,
                           coord_t x1, coord_t y1, coord_t z1);
        write_box(CFG_BOX_MIN_X, x0);
        write_box(CFG_BOX_MIN_Y, y0);
        write_box(CFG_BOX_MIN_Z, z0);
        write_box(CFG_BOX_MAX_X, x1);
        write_box(CFG_BOX_MAX_Y, y1);
        write_box(CFG_BOX_MAX_Z, z1);
    endtask

    task automatic wait_drained();
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send_ray(ray_t r, logic has_exp, hit_word_t given);
        hit_word_t w;
        int gap;
        w = slab_predict(r);
        if (has_exp)
            w = given;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            ray_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ray_ch.valid    <= 1'b1;
        ray_ch.origin_x <= r.ox;
        ray_ch.origin_y <= r.oy;
        ray_ch.origin_z <= r.oz;
        ray_ch.dir_x    <= r.dx;
        ray_ch.dir_y    <= r.dy;
        ray_ch.dir_z    <= r.dz;
        ray_ch.param_lo <= r.lo;
        ray_ch.param_hi <= r.hi;
        pending_hits.push_back(w);
        do
            @(posedge clk);
        while (!ray_ch.ready);
        rays_sent++;
    endtask

    task automatic end_burst();
        ray_ch.valid <= 1'b0;
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom);
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return 32'sd0;
            default: return coord_t'(int'($urandom_range(0, 32'h000c0000)) - 32'h00060000);
        endcase
    endfunction

    function automatic ray_t aimed_ray();
        ray_t r;
        r.ox = rand_coord();
        r.oy = rand_coord();
        r.oz = rand_coord();
        r.dx = coord_t'(int'($urandom_range(0, 32'h00040000)) - 32'h00020000);
        r.dy = coord_t'(int'($urandom_range(0, 32'h00040000)) - 32'h00020000);
        r.dz = coord_t'(int'($urandom_range(0, 32'h00040000)) - 32'h00020000);
        if ($urandom_range(0, 9) == 0)
            r.dx = 0;
        if ($urandom_range(0, 3) == 0)
        begin
            r.dx = coord_t'((box_lo[0] + box_hi[0]) / 2 - r.ox) / 4;
            r.dy = coord_t'((box_lo[1] + box_hi[1]) / 2 - r.oy) / 4;
            r.dz = coord_t'((box_lo[2] + box_hi[2]) / 2 - r.oz) / 4;
        end
        r.lo = $urandom_range(0, 7) == 0 ? rand_coord() : 32'sd0;
        r.hi = $urandom_range(0, 7) == 0 ? rand_coord() : 32'sh7fffffff;
        if ($urandom_range(0, 15) == 0)
        begin
            r.dx = coord_t'($urandom);
            r.dy = coord_t'($urandom);
            r.dz = coord_t'($urandom);
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && hit_ch.valid && hit_ch.ready)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("Result word with no ray outstanding.");
                errors++;
            end
            else
            begin
                hit_word_t e;
                e = pending_hits.pop_front();
                words_seen++;
                if (hit_ch.hit)
                    hits_seen++;
                if (hit_ch.hit !== e.hit)
                begin
                    $error("hit: expected %0d, got %0d", e.hit, hit_ch.hit);
                    errors++;
                end
                if (hit_ch.point_x !== e.px)
                begin
                    $error("point_x: expected %0d, got %0d", e.px, hit_ch.point_x);
                    errors++;
                end
                if (hit_ch.point_y !== e.py)
                begin
                    $error("point_y: expected %0d, got %0d", e.py, hit_ch.point_y);
                    errors++;
                end
                if (hit_ch.point_z !== e.pz)
                begin
                    $error("point_z: expected %0d, got %0d", e.pz, hit_ch.point_z);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int stall;
        hit_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
            if (cycles > 2000 && cycles < 2600)
                stall = 0;
            hit_ch.ready <= 1'b0;
            repeat (stall) @(posedge clk);
            hit_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!hit_ch.valid);
        end
    end

    initial
    begin
        row_t      rows[$];
        hit_word_t miss;
        ray_t      r;
        localparam coord_t ONE = 32'sh00010000;
        errors     = 0;
        cycles     = 0;
        rays_sent  = 0;
        words_seen = 0;
        hits_seen  = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        ray_ch.valid = 1'b0;
        ray_ch.origin_x = '0;
        ray_ch.origin_y = '0;
        ray_ch.origin_z = '0;
        ray_ch.dir_x = '0;
        ray_ch.dir_y = '0;
        ray_ch.dir_z = '0;
        ray_ch.param_lo = '0;
        ray_ch.param_hi = '0;
        for (int i = 0; i < 3; i++)
        begin
            box_lo[i] = 0;
            box_hi[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        miss = '{1'b0, '0, '0, '0};

        // The reset box is the single point at the origin.
        rows.push_back('{'{ONE, 0, 0, 0, 0, 0, 0, ONE}, 1'b1, miss});
        rows.push_back('{'{0, 0, 0, 0, 0, 0, -ONE, ONE}, 1'b1, '{1'b1, '0, '0, '0}});
        foreach (rows[i])
            send_ray(rows[i].r, rows[i].has_exp, rows[i].exp);
        end_burst();
        wait_drained();

        set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        rows.delete();
        rows.push_back('{'{-4*ONE, 0, 0, ONE, 0, 0, 0, 32'sh7fffffff}, 1'b0, miss});
        rows.push_back('{'{4*ONE, 0, 0, -ONE, 0, 0, 0, 32'sh7fffffff}, 1'b0, miss});
        rows.push_back('{'{0, 0, 0, ONE, ONE, ONE, 0, 32'sh7fffffff}, 1'b0, miss});
        rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, ONE}, 1'b0, miss});
        rows.push_back('{'{4*ONE, 0, 0, 0, ONE, 0, 0, 32'sh7fffffff}, 1'b1, miss});
        rows.push_back('{'{-4*ONE, 0, 0, ONE, 0, 0, ONE, ONE}, 1'b1, miss});
        rows.push_back('{'{-4*ONE, 0, 0, ONE, 0, 0, 2*ONE, -ONE}, 1'b1, miss});
        rows.push_back('{'{-4*ONE, 0, 0, -ONE, 0, 0, 0, 32'sh7fffffff}, 1'b1, miss});
        rows.push_back('{'{-4*ONE, 0, 0, ONE, 0, 0, 0, 2*ONE}, 1'b1, miss});
        rows.push_back('{'{32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff,
                           32'sh80000000, 1, 32'sh80000000, 32'sh7fffffff}, 1'b0, miss});
        rows.push_back('{'{-2*ONE, -2*ONE, -2*ONE, 1, 1, 1, 0, 32'sh7fffffff}, 1'b0, miss});
        rows.push_back('{'{ONE, ONE, ONE, -ONE, -ONE, -ONE, -ONE, 32'sh7fffffff},
                         1'b0, miss});
        rows.push_back('{'{-ONE, 0, 0, 32'sh7fffffff, 0, 0, 32'sh80000000, 32'sh7fffffff},
                         1'b0, miss});
        foreach (rows[i])
            send_ray(rows[i].r, rows[i].has_exp, rows[i].exp);
        end_burst();
        wait_drained();

        // Inverted box, then the widest possible box.
        set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
        r = '{-4*ONE, 0, 0, ONE, 0, 0, 0, 32'sh7fffffff};
        send_ray(r, 1'b0, miss);
        r = '{0, 0, 0, ONE, ONE, ONE, 0, 32'sh7fffffff};
        send_ray(r, 1'b0, miss);
        end_burst();
        wait_drained();
        set_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        r = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff, 32'sh80000000, ONE,
              32'sh80000000, 32'sh7fffffff};
        send_ray(r, 1'b0, miss);
        end_burst();
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
                1: set_box(-8*ONE, -2*ONE, 0, 3*ONE, 5*ONE, ONE / 4);
                2: set_box(32'sh80000000, -ONE, -ONE, 32'sh7fffffff, ONE, ONE);
                default: set_box(coord_t'(-$urandom_range(1, 32'h00080000)),
                                 coord_t'(-$urandom_range(1, 32'h00080000)),
                                 coord_t'(-$urandom_range(1, 32'h00080000)),
                                 coord_t'($urandom_range(0, 32'h00080000)),
                                 coord_t'($urandom_range(0, 32'h00080000)),
                                 coord_t'($urandom_range(0, 32'h00080000)));
            endcase
            for (int n = 0; n < RANDOM_RAYS / 4; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    r = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord()};
                else
                    r = aimed_ray();
                send_ray(r, 1'b0, miss);
            end
            end_burst();
            wait_drained();
        end

        $display("Sent %0d rays over eight box settings; %0d result words checked, %0d hits.",
                 rays_sent, words_seen, hits_seen);
        if (errors == 0 && pending_hits.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
